FILE: rtl/core/lkv_pkg.sv
// lkv_pkg: shared types and constants for the lru key/value cache
// used by lru_key_value_cache and its testbench; no dependencies
package lkv_pkg;

  localparam int KEY_W = 14;
  localparam int VAL_W = 32;
  localparam int CAP_W = 15;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } out_t;

endpackage

FILE: rtl/core/lkv_ram.sv
// lkv_ram: single write port, single read port memory with registered read
// no package dependencies
module lkv_ram #(
  parameter int W     = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/lru_key_value_cache.sv
// lru_key_value_cache: key-indexed lru cache with a doubly linked recency list
// depends on lkv_pkg and lkv_ram
// After reset the block runs a clearing pass over the valid/value memory, one entry
// per cycle, and accepts no item until it is done. Each item is then handled by a
// sequencer around three memories with one write and one read port (valid+value,
// newer link, older link) and a registered read. A get reads all three, then emits a
// miss or a hit on the newest key, or unlinks and relinks the key as newest before
// emitting; an out-of-range get emits a miss and an out-of-range put is dropped. A put
// of a present key writes the value and, unless newest, unlinks and relinks it; a put
// of an absent key evicts the oldest first when full, then inserts it as newest. A get
// waits in its emit step while the previous result is stalled. A get result waits in
// an output register while the next item is accepted.
module lru_key_value_cache #(
  parameter int KEY_SPACE = 16384
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lkv_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lkv_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_data
);

  localparam int KW = $clog2(KEY_SPACE);
  localparam int VW = lkv_pkg::VAL_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_UNL  = 3'd3;
  localparam logic [2:0] S_PSH  = 3'd4;
  localparam logic [2:0] S_EVR  = 3'd5;
  localparam logic [2:0] S_INS  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [KW-1:0]            clr_r, clr_nxt;
  logic [KW-1:0]            newest_r, newest_nxt;
  logic [KW-1:0]            oldest_r, oldest_nxt;
  logic [KW:0]              occ_r, occ_nxt;
  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic                     cmd_r, cmd_nxt;
  logic [KW-1:0]            key_r, key_nxt;
  logic [VW-1:0]            val_r, val_nxt;
  logic [KW-1:0]            nw_r, nw_nxt;
  logic [KW-1:0]            od_r, od_nxt;
  lkv_pkg::out_t            res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  lkv_pkg::out_t            out_r, out_nxt;

  logic                     re;
  logic [KW-1:0]            raddr;
  logic                     v_we, n_we, o_we;
  logic [KW-1:0]            v_wa, n_wa, o_wa;
  logic [VW:0]              v_wd, v_rd;
  logic [KW-1:0]            n_wd, o_wd, n_rd, o_rd;

  logic                     in_xfer;
  logic                     in_rng;
  logic [lkv_pkg::CAP_W-1:0] cap_eff;
  logic                     full;

  lkv_ram #(.W(VW + 1), .DEPTH(KEY_SPACE)) u_val (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd),
    .re(re), .raddr(raddr), .rdata(v_rd)
  );

  lkv_ram #(.W(KW), .DEPTH(KEY_SPACE)) u_newer (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd),
    .re(re), .raddr(raddr), .rdata(n_rd)
  );

  lkv_ram #(.W(KW), .DEPTH(KEY_SPACE)) u_older (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd),
    .re(re), .raddr(raddr), .rdata(o_rd)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign in_rng   = (32'(in_data.key) < 32'(KEY_SPACE));
  assign cap_eff  = (cap_r == '0) ? lkv_pkg::CAP_W'(1) : cap_r;
  assign full     = (32'(occ_r) >= 32'(cap_eff)) && (occ_r != '0);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    occ_nxt       = occ_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    nw_nxt        = nw_r;
    od_nxt        = od_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    re            = 1'b0;
    raddr         = KW'(in_data.key);
    v_we          = 1'b0;
    v_wa          = key_r;
    v_wd          = {1'b1, val_r};
    n_we          = 1'b0;
    n_wa          = od_r;
    n_wd          = nw_r;
    o_we          = 1'b0;
    o_wa          = nw_r;
    o_wd          = od_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        v_we    = 1'b1;
        v_wa    = clr_r;
        v_wd    = '0;
        clr_nxt = clr_r + KW'(1);
        if (clr_r == KW'(KEY_SPACE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt = in_data.command;
          key_nxt = KW'(in_data.key);
          val_nxt = in_data.value;
          res_nxt = '0;
          if (in_rng) begin
            re        = 1'b1;
            state_nxt = S_RD;
          end else if (in_data.command == lkv_pkg::CMD_GET) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_RD: begin
        nw_nxt = n_rd;
        od_nxt = o_rd;
        if (cmd_r == lkv_pkg::CMD_GET) begin
          if (!v_rd[VW]) begin
            state_nxt = S_EMIT;
          end else begin
            res_nxt.found      = 1'b1;
            res_nxt.read_value = v_rd[VW-1:0];
            state_nxt = (key_r == newest_r) ? S_EMIT : S_UNL;
          end
        end else if (v_rd[VW]) begin
          v_we      = 1'b1;
          state_nxt = (key_r == newest_r) ? S_IDLE : S_UNL;
        end else if (full) begin
          // fetch the victim's newer link
          re        = 1'b1;
          raddr     = oldest_r;
          state_nxt = S_EVR;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_UNL: begin
        if (key_r == oldest_r) begin
          oldest_nxt = nw_r;
        end else begin
          n_we = 1'b1;
          o_we = 1'b1;
        end
        state_nxt = S_PSH;
      end
      S_PSH: begin
        o_we       = 1'b1;
        o_wa       = key_r;
        o_wd       = newest_r;
        n_we       = 1'b1;
        n_wa       = newest_r;
        n_wd       = key_r;
        newest_nxt = key_r;
        state_nxt  = (cmd_r == lkv_pkg::CMD_GET) ? S_EMIT : S_IDLE;
      end
      S_EVR: begin
        v_we = 1'b1;
        v_wa = oldest_r;
        v_wd = '0;
        if (occ_r > (KW + 1)'(1)) begin
          oldest_nxt = n_rd;
        end
        occ_nxt   = occ_r - (KW + 1)'(1);
        state_nxt = S_INS;
      end
      S_INS: begin
        v_we = 1'b1;
        if (occ_r == '0) begin
          newest_nxt = key_r;
          oldest_nxt = key_r;
        end else begin
          o_we       = 1'b1;
          o_wa       = key_r;
          o_wd       = newest_r;
          n_we       = 1'b1;
          n_wa       = newest_r;
          n_wd       = key_r;
          newest_nxt = key_r;
        end
        occ_nxt   = occ_r + (KW + 1)'(1);
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        // wait for the previous result to drain
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      newest_r    <= '0;
      oldest_r    <= '0;
      occ_r       <= '0;
      cap_r       <= lkv_pkg::CAP_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    nw_r  <= nw_nxt;
    od_r  <= od_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= 32'(KEY_SPACE))
    else $error("occupancy beyond key space");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EVR && state_r != S_INS) |=> occ_r == $past(occ_r))
    else $error("occupancy moved outside evict or insert");

  a_push_newest: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PSH |=> newest_r == $past(key_r))
    else $error("relinked key is not newest");

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for lru_key_value_cache
// depends on lkv_pkg and the cache rtl; predicts each get result with its own lru list model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEYS      = 16384;
  localparam int CYCLE_CAP = 800000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  lkv_pkg::in_t  in_data;
  lkv_pkg::out_t out_data;
  logic [lkv_pkg::CAP_W-1:0] cfg_data;

  lru_key_value_cache #(.KEY_SPACE(KEYS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // lru list shadow
  bit                          slot_used [KEYS];
  logic [lkv_pkg::VAL_W-1:0]   slot_val  [KEYS];
  logic [lkv_pkg::KEY_W-1:0]   link_newer[KEYS];
  logic [lkv_pkg::KEY_W-1:0]   link_older[KEYS];
  logic [lkv_pkg::KEY_W-1:0]   head_new, tail_old;
  int unsigned                 held, cap_limit;

  lkv_pkg::in_t  cmd_q[$];
  lkv_pkg::out_t lookup_q[$];
  int   gap_left, stall_left, errors, cycles;
  int   n_get, n_hit, n_put, n_evict;
  bit   quiet;

  task automatic promote(input logic [lkv_pkg::KEY_W-1:0] k);
    logic [lkv_pkg::KEY_W-1:0] nw, od;
    if (k != head_new) begin
      nw = link_newer[k];
      od = link_older[k];
      if (k == tail_old) tail_old = nw;
      else begin
        link_newer[od] = nw;
        link_older[nw] = od;
      end
      link_older[k] = head_new;
      link_newer[head_new] = k;
      head_new = k;
    end
  endtask

  task automatic apply_cmd(input lkv_pkg::in_t it);
    int unsigned lim;
    logic [lkv_pkg::KEY_W-1:0] victim;
    lkv_pkg::out_t r;
    if (it.command == lkv_pkg::CMD_GET) begin
      n_get++;
      if (slot_used[it.key]) begin
        n_hit++;
        promote(it.key);
        r.found = 1'b1;
        r.read_value = slot_val[it.key];
      end else begin
        r.found = 1'b0;
        r.read_value = '0;
      end
      lookup_q.push_back(r);
    end else begin
      n_put++;
      if (slot_used[it.key]) begin
        slot_val[it.key] = it.value;
        promote(it.key);
      end else begin
        lim = (cap_limit == 0) ? 1 : cap_limit;
        if (held >= lim && held > 0) begin
          n_evict++;
          victim = tail_old;
          slot_used[victim] = 1'b0;
          if (held > 1) tail_old = link_newer[victim];
          held--;
        end
        slot_used[it.key] = 1'b1;
        slot_val[it.key] = it.value;
        if (held == 0) begin
          head_new = it.key;
          tail_old = it.key;
        end else begin
          link_older[it.key] = head_new;
          link_newer[head_new] = it.key;
          head_new = it.key;
        end
        held++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t timeout with %0d results outstanding", $time, lookup_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_data  <= cmd_q.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predictor runs on each accepted input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) apply_cmd(in_data);
  end

  // monitor and result-side stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 16);
      end
      if (out_valid && !out_stall) begin
        if (lookup_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: actual found=%0b value=%h", $time,
                   out_data.found, out_data.read_value);
        end else begin
          if (out_data.found !== lookup_q[0].found) begin
            errors++;
            $display("%0t found mismatch: expected %0b actual %0b", $time,
                     lookup_q[0].found, out_data.found);
          end
          if (out_data.read_value !== lookup_q[0].read_value) begin
            errors++;
            $display("%0t read_value mismatch: expected %h actual %h", $time,
                     lookup_q[0].read_value, out_data.read_value);
          end
          void'(lookup_q.pop_front());
        end
      end
    end
  end

  task automatic push_cmd(input logic c, input int k,
                          input logic [lkv_pkg::VAL_W-1:0] v);
    lkv_pkg::in_t it;
    it.command = c;
    it.key     = k[lkv_pkg::KEY_W-1:0];
    it.value   = v;
    cmd_q.push_back(it);
  endtask

  // block until every item is sent and every get result is back, then let puts drain
  task automatic drain();
    do @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || lookup_q.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_capacity(input int unsigned c);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= c[lkv_pkg::CAP_W-1:0];
    cap_limit = c[lkv_pkg::CAP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_burst(input int unsigned c, input int pool, input int count);
    int k;
    set_capacity(c);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       k = $urandom_range(0, KEYS - 1);
        1:       k = KEYS - 1 - $urandom_range(0, 3);
        default: k = $urandom_range(0, pool - 1);
      endcase
      push_cmd($urandom_range(0, 1) ? lkv_pkg::CMD_PUT : lkv_pkg::CMD_GET, k, $urandom());
      // sender holds off once mid-phase until all results are in
      if (i == count / 2 && c == 8) drain();
    end
    drain();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    quiet  = 1'b0;
    n_get = 0; n_hit = 0; n_put = 0; n_evict = 0;
    held = 0; head_new = '0; tail_old = '0; cap_limit = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // smallest capacity: every new key evicts the last
    set_capacity(1);
    push_cmd(lkv_pkg::CMD_GET, 0, '0);
    push_cmd(lkv_pkg::CMD_PUT, 0, 32'h7fffffff);
    push_cmd(lkv_pkg::CMD_GET, 0, '0);
    push_cmd(lkv_pkg::CMD_PUT, KEYS - 1, 32'h80000000);
    push_cmd(lkv_pkg::CMD_GET, 0, '0);
    push_cmd(lkv_pkg::CMD_GET, KEYS - 1, '0);
    push_cmd(lkv_pkg::CMD_PUT, KEYS - 1, 32'hffffffff);
    push_cmd(lkv_pkg::CMD_GET, KEYS - 1, 32'hffffffff);
    drain();

    // zero capacity acts as one
    set_capacity(0);
    push_cmd(lkv_pkg::CMD_PUT, 5, 32'h00000001);
    push_cmd(lkv_pkg::CMD_PUT, 6, 32'h00000002);
    push_cmd(lkv_pkg::CMD_GET, 5, '0);
    push_cmd(lkv_pkg::CMD_GET, 6, '0);
    drain();

    // moves from oldest, middle and newest position, update and eviction
    set_capacity(4);
    for (int k = 1; k <= 4; k++) push_cmd(lkv_pkg::CMD_PUT, k, 32'h55aa0000 + k);
    push_cmd(lkv_pkg::CMD_GET, 1, '0);
    push_cmd(lkv_pkg::CMD_GET, 3, '0);
    push_cmd(lkv_pkg::CMD_GET, 3, '0);
    push_cmd(lkv_pkg::CMD_PUT, 2, 32'hdeadbeef);
    push_cmd(lkv_pkg::CMD_PUT, 9, 32'h12345678);
    push_cmd(lkv_pkg::CMD_GET, 4, '0);
    push_cmd(lkv_pkg::CMD_GET, 2, '0);
    drain();

    // capacity lowered below occupancy: one eviction per new key
    set_capacity(2);
    push_cmd(lkv_pkg::CMD_PUT, 10, 32'h0badf00d);
    push_cmd(lkv_pkg::CMD_GET, 1, '0);
    push_cmd(lkv_pkg::CMD_GET, 10, '0);
    drain();

    random_burst(3, 8, 240);
    random_burst(8, 20, 240);
    random_burst(32767, 64, 240);
    random_burst(32, 64, 240);
    random_burst(1, 4, 200);
    random_burst(16384, 48, 240);
    quiet = 1'b1;
    random_burst(100, 160, 220);

    $display("covered %0d gets (%0d hits), %0d puts, %0d evictions", n_get, n_hit, n_put,
             n_evict);
    $display("capacities from 0 to 32767, key extremes and full-range values");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
